@@ rtl/rpsh_pkg.sv @@
// shared types and codes of the read position statistics histogram
package rpsh_pkg;

    localparam logic [1:0] OP_BASE    = 2'd0;
    localparam logic [1:0] OP_EMPTY   = 2'd1;
    localparam logic [1:0] OP_READOUT = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [2:0] TBL_BASE_POS = 3'd0;
    localparam logic [2:0] TBL_QUAL_POS = 3'd1;
    localparam logic [2:0] TBL_LENGTH   = 3'd2;
    localparam logic [2:0] TBL_BASE_ALL = 3'd3;
    localparam logic [2:0] TBL_QUAL_ALL = 3'd4;
    localparam logic [2:0] TBL_SCALAR   = 3'd5;

    localparam logic [5:0] SCL_READS    = 6'd0;
    localparam logic [5:0] SCL_BASES    = 6'd1;
    localparam logic [5:0] SCL_LONGEST  = 6'd2;
    localparam logic [5:0] SCL_TOP_QUAL = 6'd3;

    localparam logic KIND_READ_END = 1'b0;
    localparam logic KIND_READOUT  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LONG  = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    localparam int         NUM_BASES = 5;
    localparam logic [2:0] BASE_N    = 3'd4;

    localparam logic [2:0] SRC_DIRECT   = 3'd0;
    localparam logic [2:0] SRC_BASE_POS = 3'd1;
    localparam logic [2:0] SRC_QUAL_POS = 3'd2;
    localparam logic [2:0] SRC_LENGTH   = 3'd3;
    localparam logic [2:0] SRC_QUAL_ALL = 3'd4;

    localparam int         OUT_SLOTS = 3;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  base_code;
        logic [5:0]  quality;
        logic        last_in_read;
        logic [2:0]  table_select;
        logic [10:0] position;
        logic [5:0]  bin;
    } feed_word_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic [1:0]  status;
    } report_word_t;

    typedef struct packed {
        logic valid;
        logic bump;
        logic clear;
    } bank_ctl_t;

endpackage

@@ rtl/rpsh_feed_if.sv @@
// input channel carrying one base, empty read, readout or clear word
interface rpsh_feed_if;
    logic                  valid;
    logic                  ready;
    rpsh_pkg::feed_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/rpsh_report_if.sv @@
// output channel carrying end-of-read status and counter readout words
interface rpsh_report_if;
    logic                    valid;
    logic                    ready;
    rpsh_pkg::report_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/rpsh_count_bank.sv @@
// counter memory with read-modify-write, write forwarding and clearing sweep
module rpsh_count_bank #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rpsh_pkg::bank_ctl_t       ctl,
    input  logic [$clog2(DEPTH)-1:0]  addr,
    output logic [WIDTH-1:0]          count,
    output logic                      busy
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic             s1_bump_reg;
    logic             fwd_valid_reg;
    logic [AW-1:0]    fwd_addr_reg;
    logic [WIDTH-1:0] fwd_data_reg;
    logic             sweep_reg;
    logic [AW-1:0]    sweep_addr_reg;

    logic             fwd_hit;
    logic [WIDTH-1:0] cur;
    logic [WIDTH-1:0] bumped;
    logic             bump_wr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [WIDTH-1:0] wr_data;

    // the word read in the cycle of the previous write sees the old entry
    assign fwd_hit = fwd_valid_reg && (fwd_addr_reg == s1_addr_reg);
    assign cur     = fwd_hit ? fwd_data_reg : rd_data_reg;
    assign bumped  = (&cur) ? cur : cur + WIDTH'(1);
    assign bump_wr = s1_bump_reg && !sweep_reg;
    assign wr_en   = sweep_reg || bump_wr;
    assign wr_addr = sweep_reg ? sweep_addr_reg : s1_addr_reg;
    assign wr_data = sweep_reg ? '0 : bumped;
    assign count   = cur;
    assign busy    = sweep_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.valid)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            s1_addr_reg <= addr;
        end
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= bumped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_bump_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
        end
        else
        begin
            s1_bump_reg   <= ctl.valid && ctl.bump;
            fwd_valid_reg <= bump_wr;
            if (sweep_reg)
            begin
                if (sweep_addr_reg == AW'(DEPTH - 1))
                begin
                    sweep_reg <= 1'b0;
                end
                sweep_addr_reg <= sweep_addr_reg + AW'(1);
            end
            else if (ctl.valid && ctl.clear)
            begin
                sweep_reg      <= 1'b1;
                sweep_addr_reg <= '0;
            end
        end
    end

endmodule

@@ rtl/rpsh_out_queue.sv @@
// three-slot result queue between the update pipeline and the report channel
module rpsh_out_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rpsh_pkg::report_word_t  push_word,
    rpsh_report_if.source           report,
    output logic [1:0]              fill
);

    localparam logic [1:0] LAST_SLOT = 2'(rpsh_pkg::OUT_SLOTS - 1);

    rpsh_pkg::report_word_t slot_reg [rpsh_pkg::OUT_SLOTS];
    logic [1:0] head_reg;
    logic [1:0] tail_reg;
    logic [1:0] fill_reg;
    logic       pop;

    assign report.valid = (fill_reg != 2'd0);
    assign report.data  = slot_reg[head_reg];
    assign pop          = report.valid && report.ready;
    assign fill         = fill_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= (tail_reg == LAST_SLOT) ? 2'd0 : tail_reg + 2'd1;
            end
            if (pop)
            begin
                head_reg <= (head_reg == LAST_SLOT) ? 2'd0 : head_reg + 2'd1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/read_position_stats_histogram.sv @@
// top level of the read position statistics histogram
// One word per clock is taken, back to back: bases, empty reads, readouts and clears. Every
// base within MAX_POSITIONS bumps its per-position base and quality counters and the overall
// quality counter, each held in a memory with a registered read and write-back, with the last
// write forwarded so neighboring words on the same counter count correctly. A result word
// turns valid on report at the clock edge after the one that takes its input word; input
// stalls when three results are queued or in flight, and while memories are swept. After reset
// and after each clear word the memories are swept to zero, one entry per cycle, across all
// entries of the deepest counter memory, the larger of 5*MAX_POSITIONS and
// 2^(ceil(log2 MAX_POSITIONS) + ceil(log2 QUALITY_LEVELS)) (65536 at the defaults); no word
// is taken during the sweep. Counters saturate at 2^COUNT_BITS-1 and are read out saturated
// to 32 bits.
module read_position_stats_histogram #(
    parameter int MAX_POSITIONS  = 1024,
    parameter int QUALITY_LEVELS = 64,
    parameter int COUNT_BITS     = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    rpsh_feed_if.sink      feed,
    rpsh_report_if.source  report
);

    localparam int PW       = $clog2(MAX_POSITIONS);
    localparam int LW       = $clog2(MAX_POSITIONS + 1);
    localparam int QW       = $clog2(QUALITY_LEVELS);
    localparam int PXW      = (LW > 11) ? LW : 11;
    localparam int BP_DEPTH = MAX_POSITIONS * rpsh_pkg::NUM_BASES;
    localparam int BAW      = $clog2(BP_DEPTH);
    localparam int QP_DEPTH = 2 ** (PW + QW);

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [31:0] sat32(input logic [COUNT_BITS-1:0] v);
        logic [63:0] w64;
        w64 = 64'(v);
        return (w64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w64[31:0];
    endfunction

    // scalar state
    logic [LW-1:0]         cur_pos_reg;
    logic                  too_long_reg;
    logic [COUNT_BITS-1:0] reads_reg;
    logic [COUNT_BITS-1:0] bases_reg;
    logic [LW-1:0]         longest_reg;
    logic [QW-1:0]         top_qual_reg;
    logic [COUNT_BITS-1:0] base_all_reg [rpsh_pkg::NUM_BASES];

    // second stage
    logic        s1_valid_reg;
    logic        s1_res_reg;
    logic        s1_kind_reg;
    logic [2:0]  s1_src_reg;
    logic [31:0] s1_value_reg;
    logic [1:0]  s1_status_reg;

    rpsh_pkg::feed_word_t   w;
    rpsh_pkg::report_word_t push_word;
    rpsh_pkg::bank_ctl_t    pos_ctl;
    rpsh_pkg::bank_ctl_t    len_ctl;

    logic          accept;
    logic          is_base;
    logic          is_empty;
    logic          is_read;
    logic          is_clear;
    logic          room;
    logic          ends;
    logic [2:0]    b_cl;
    logic [2:0]    bb;
    logic [8:0]    q9;
    logic [8:0]    q_cl9;
    logic [8:0]    bin9;
    logic [QW-1:0] q_idx;
    logic [QW-1:0] qq;
    logic [PXW-1:0] pos_x;
    logic [PW-1:0] pp;
    logic [LW-1:0] cur_inc;
    logic [LW-1:0] len_end;
    logic [BAW-1:0] bp_base;
    logic [BAW-1:0] bp_addr;
    logic [PW+QW-1:0] qp_addr;
    logic [LW-1:0] len_addr;
    logic          pos_ok;
    logic          pos_len_ok;
    logic          bin_base_ok;
    logic          bin_qual_ok;
    logic [2:0]    bo_idx;
    logic [COUNT_BITS-1:0] bo_cur;

    logic          s0_res;
    logic          s0_kind;
    logic [2:0]    s0_src;
    logic [31:0]   s0_value;
    logic [1:0]    s0_status;

    logic [COUNT_BITS-1:0] bp_count;
    logic [COUNT_BITS-1:0] qp_count;
    logic [COUNT_BITS-1:0] len_count;
    logic [COUNT_BITS-1:0] qa_count;
    logic bp_busy;
    logic qp_busy;
    logic len_busy;
    logic qa_busy;
    logic busy;
    logic push;
    logic [1:0] fill;
    logic [31:0] s1_value;

    assign w        = feed.data;
    assign busy     = bp_busy || qp_busy || len_busy || qa_busy;
    assign feed.ready = !busy
                      && ((3'({1'b0, fill}) + 3'({2'b0, s1_res_reg}))
                          < 3'(rpsh_pkg::OUT_SLOTS));
    assign accept   = feed.valid && feed.ready;
    assign is_base  = (w.op == rpsh_pkg::OP_BASE);
    assign is_empty = (w.op == rpsh_pkg::OP_EMPTY);
    assign is_read  = (w.op == rpsh_pkg::OP_READOUT);
    assign is_clear = (w.op == rpsh_pkg::OP_CLEAR);
    assign ends     = is_base && w.last_in_read;

    // input clamps
    assign b_cl  = (w.base_code > rpsh_pkg::BASE_N) ? rpsh_pkg::BASE_N : w.base_code;
    assign q9    = {3'b000, w.quality};
    assign q_cl9 = (q9 >= 9'(QUALITY_LEVELS)) ? 9'(QUALITY_LEVELS - 1) : q9;
    assign q_idx = q_cl9[QW-1:0];
    assign bin9  = {3'b000, w.bin};
    assign pos_x = PXW'(w.position);

    assign room    = cur_pos_reg < LW'(MAX_POSITIONS);
    assign cur_inc = cur_pos_reg + LW'(1);
    assign len_end = room ? cur_inc : cur_pos_reg;

    // memory addresses
    assign pp       = is_read ? pos_x[PW-1:0] : cur_pos_reg[PW-1:0];
    assign bb       = is_read ? w.bin[2:0] : b_cl;
    assign qq       = is_read ? bin9[QW-1:0] : q_idx;
    assign bp_base  = BAW'(pp);
    assign bp_addr  = (bp_base << 2) + bp_base + BAW'(bb);
    assign qp_addr  = {pp, qq};
    assign len_addr = is_read ? pos_x[LW-1:0] : (is_empty ? '0 : len_end);

    assign pos_ok      = pos_x < PXW'(MAX_POSITIONS);
    assign pos_len_ok  = pos_x <= PXW'(MAX_POSITIONS);
    assign bin_base_ok = w.bin < 6'(rpsh_pkg::NUM_BASES);
    assign bin_qual_ok = bin9 < 9'(QUALITY_LEVELS);

    assign bo_idx = is_read ? w.bin[2:0] : b_cl;
    assign bo_cur = (bo_idx <= rpsh_pkg::BASE_N) ? base_all_reg[bo_idx] : '0;

    assign pos_ctl = '{valid: accept, bump: is_base && room, clear: is_clear};
    assign len_ctl = '{valid: accept, bump: ends || is_empty, clear: is_clear};

    always_comb
    begin
        s0_res    = 1'b0;
        s0_kind   = rpsh_pkg::KIND_READ_END;
        s0_src    = rpsh_pkg::SRC_DIRECT;
        s0_value  = '0;
        s0_status = rpsh_pkg::ST_OK;
        if (ends)
        begin
            s0_res    = 1'b1;
            s0_value  = 32'(len_end);
            s0_status = (too_long_reg || !room) ? rpsh_pkg::ST_TOO_LONG : rpsh_pkg::ST_OK;
        end
        else if (is_empty)
        begin
            s0_res = 1'b1;
        end
        else if (is_read)
        begin
            s0_res    = 1'b1;
            s0_kind   = rpsh_pkg::KIND_READOUT;
            s0_status = rpsh_pkg::ST_BAD_INDEX;
            case (w.table_select)
                rpsh_pkg::TBL_BASE_POS:
                begin
                    if (pos_ok && bin_base_ok)
                    begin
                        s0_src    = rpsh_pkg::SRC_BASE_POS;
                        s0_status = rpsh_pkg::ST_OK;
                    end
                end
                rpsh_pkg::TBL_QUAL_POS:
                begin
                    if (pos_ok && bin_qual_ok)
                    begin
                        s0_src    = rpsh_pkg::SRC_QUAL_POS;
                        s0_status = rpsh_pkg::ST_OK;
                    end
                end
                rpsh_pkg::TBL_LENGTH:
                begin
                    if (pos_len_ok)
                    begin
                        s0_src    = rpsh_pkg::SRC_LENGTH;
                        s0_status = rpsh_pkg::ST_OK;
                    end
                end
                rpsh_pkg::TBL_BASE_ALL:
                begin
                    if (bin_base_ok)
                    begin
                        s0_value  = sat32(bo_cur);
                        s0_status = rpsh_pkg::ST_OK;
                    end
                end
                rpsh_pkg::TBL_QUAL_ALL:
                begin
                    if (bin_qual_ok)
                    begin
                        s0_src    = rpsh_pkg::SRC_QUAL_ALL;
                        s0_status = rpsh_pkg::ST_OK;
                    end
                end
                rpsh_pkg::TBL_SCALAR:
                begin
                    s0_status = rpsh_pkg::ST_OK;
                    case (w.bin)
                        rpsh_pkg::SCL_READS:    s0_value = sat32(reads_reg);
                        rpsh_pkg::SCL_BASES:    s0_value = sat32(bases_reg);
                        rpsh_pkg::SCL_LONGEST:  s0_value = 32'(longest_reg);
                        rpsh_pkg::SCL_TOP_QUAL: s0_value = 32'(top_qual_reg);
                        default:                s0_status = rpsh_pkg::ST_BAD_INDEX;
                    endcase
                end
                default:
                begin
                    s0_status = rpsh_pkg::ST_BAD_INDEX;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pos_reg  <= '0;
            too_long_reg <= 1'b0;
            reads_reg    <= '0;
            bases_reg    <= '0;
            longest_reg  <= '0;
            top_qual_reg <= '0;
            for (int i = 0; i < rpsh_pkg::NUM_BASES; i++)
            begin
                base_all_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (is_clear)
            begin
                cur_pos_reg  <= '0;
                too_long_reg <= 1'b0;
                reads_reg    <= '0;
                bases_reg    <= '0;
                longest_reg  <= '0;
                top_qual_reg <= '0;
                for (int i = 0; i < rpsh_pkg::NUM_BASES; i++)
                begin
                    base_all_reg[i] <= '0;
                end
            end
            if (is_base)
            begin
                if (room)
                begin
                    bases_reg            <= sat_inc(bases_reg);
                    base_all_reg[b_cl]   <= sat_inc(bo_cur);
                    if (q_idx > top_qual_reg)
                    begin
                        top_qual_reg <= q_idx;
                    end
                end
                if (w.last_in_read)
                begin
                    cur_pos_reg  <= '0;
                    too_long_reg <= 1'b0;
                    reads_reg    <= sat_inc(reads_reg);
                    if (len_end > longest_reg)
                    begin
                        longest_reg <= len_end;
                    end
                end
                else if (room)
                begin
                    cur_pos_reg <= cur_inc;
                end
                else
                begin
                    too_long_reg <= 1'b1;
                end
            end
            if (is_empty)
            begin
                reads_reg <= sat_inc(reads_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_res_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_res_reg   <= accept && s0_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg   <= s0_kind;
            s1_src_reg    <= s0_src;
            s1_value_reg  <= s0_value;
            s1_status_reg <= s0_status;
        end
    end

    rpsh_count_bank #(
        .DEPTH (BP_DEPTH),
        .WIDTH (COUNT_BITS)
    ) u_base_pos (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (pos_ctl),
        .addr  (bp_addr),
        .count (bp_count),
        .busy  (bp_busy)
    );

    rpsh_count_bank #(
        .DEPTH (QP_DEPTH),
        .WIDTH (COUNT_BITS)
    ) u_qual_pos (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (pos_ctl),
        .addr  (qp_addr),
        .count (qp_count),
        .busy  (qp_busy)
    );

    rpsh_count_bank #(
        .DEPTH (MAX_POSITIONS + 1),
        .WIDTH (COUNT_BITS)
    ) u_length (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (len_ctl),
        .addr  (len_addr),
        .count (len_count),
        .busy  (len_busy)
    );

    rpsh_count_bank #(
        .DEPTH (QUALITY_LEVELS),
        .WIDTH (COUNT_BITS)
    ) u_qual_all (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (pos_ctl),
        .addr  (qq),
        .count (qa_count),
        .busy  (qa_busy)
    );

    always_comb
    begin
        case (s1_src_reg)
            rpsh_pkg::SRC_BASE_POS: s1_value = sat32(bp_count);
            rpsh_pkg::SRC_QUAL_POS: s1_value = sat32(qp_count);
            rpsh_pkg::SRC_LENGTH:   s1_value = sat32(len_count);
            rpsh_pkg::SRC_QUAL_ALL: s1_value = sat32(qa_count);
            default:                s1_value = s1_value_reg;
        endcase
    end

    assign push      = s1_valid_reg && s1_res_reg;
    assign push_word = '{kind: s1_kind_reg, value: s1_value, status: s1_status_reg};

    rpsh_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .report    (report),
        .fill      (fill)
    );

endmodule
